// ----- src/mavg_pkg.sv -----
// mavg_pkg: shared types and constants for the moving average filter
// no dependencies; used by moving_average_filter_unit and its test bench
package mavg_pkg;

	// window length register
	localparam int LEN_W = 7;
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ----- src/moving_average_filter_unit.sv -----
// Items that do not fill the window are taken without a divide. An item that completes it
// starts the bit-serial divider (ST_DIV), retiring one quotient bit per cycle; ST_FIN then
// registers the average and raises out_valid, waiting while an earlier result is stalled.
// in_ready is low in ST_DIV and ST_FIN, so no item is taken until the result is registered.
// Reset (arst_n low, asynchronous): sum, count and pointer clear, window length returns to 8,
// no result pending. The window store is not cleared and needs no clearing pass.
// Depends on: mavg_pkg
module moving_average_filter_unit #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mavg_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average
);

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int CMP_W = (mavg_pkg::LEN_W > CNT_W) ? mavg_pkg::LEN_W : CNT_W;
	localparam int REM_W = CNT_W + 1;
	localparam int AW    = CNT_W + 1;
	localparam int BC_W  = $clog2(SUM_W);

	mavg_pkg::state_t state_q, state_d;

	logic [mavg_pkg::LEN_W-1:0] len_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           oldest_q;
	logic [SAMPLE_BITS-1:0]     rd_q;
	logic [SUM_W-1:0]           dvd_q;
	logic [REM_W-1:0]           rem_q;
	logic                       neg_q;
	logic [BC_W-1:0]            bit_q;
	logic [SAMPLE_BITS-1:0]     avg_q;
	logic                       out_valid_q;

	logic [SAMPLE_BITS-1:0]     window_store_q [WINDOW_MAX];

	logic                       accept;
	logic                       fin_go;
	logic [CMP_W-1:0]           len_ext;
	logic [CMP_W-1:0]           eff_w;
	logic [CNT_W-1:0]           eff_len;
	logic [SUM_W-1:0]           base_sum;
	logic [CNT_W-1:0]           base_cnt;
	logic [PTR_W-1:0]           slot;
	logic [PTR_W-1:0]           wp_next;
	logic [SUM_W-1:0]           sample_ext;
	logic [SUM_W-1:0]           new_sum;
	logic [SUM_W-1:0]           new_mag;
	logic [CNT_W:0]             cnt_inc;
	logic                       win_full;
	logic [AW-1:0]              slot1;
	logic [AW-1:0]              oldest_w;
	logic [REM_W-1:0]           rem_sh;
	logic [REM_W-1:0]           div_len;
	logic                       q_bit;
	logic [REM_W-1:0]           rem_nx;
	logic [SUM_W-1:0]           quot_signed;
	logic [SUM_W-1:0]           rd_ext;

	// effective window length: zero acts as one, above the store depth acts as the depth
	always_comb begin
		len_ext = CMP_W'(len_q);
		if (len_ext == '0) begin
			eff_w = CMP_W'(1);
		end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
			eff_w = CMP_W'(WINDOW_MAX);
		end else begin
			eff_w = len_ext;
		end
		eff_len = eff_w[CNT_W-1:0];
	end

	// intake: block start, running sum, fill check and oldest slot
	always_comb begin
		base_sum   = block_start ? '0 : sum_q;
		base_cnt   = block_start ? '0 : cnt_q;
		slot       = block_start ? '0 : wp_q;
		wp_next    = (slot == PTR_W'(WINDOW_MAX - 1)) ? '0 : slot + PTR_W'(1);
		sample_ext = {{(SUM_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
		new_sum    = base_sum + sample_ext;
		new_mag    = new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
		cnt_inc    = {1'b0, base_cnt} + (CNT_W + 1)'(1);
		win_full   = !(cnt_inc < {1'b0, eff_len});
		slot1      = AW'(slot) + AW'(1);
		if (slot1 >= AW'(eff_len)) begin
			oldest_w = slot1 - AW'(eff_len);
		end else begin
			oldest_w = slot1 + AW'(WINDOW_MAX) - AW'(eff_len);
		end
	end

	// one restoring division step per cycle
	always_comb begin
		div_len = {1'b0, eff_len};
		rem_sh  = {rem_q[REM_W-2:0], dvd_q[SUM_W-1]};
		q_bit   = (rem_sh >= div_len);
		rem_nx  = q_bit ? (rem_sh - div_len) : rem_sh;
	end

	// result sign and the sample that leaves the window
	always_comb begin
		quot_signed = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;
		rd_ext      = {{(SUM_W - SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == mavg_pkg::ST_IDLE);
		accept   = in_valid && in_ready;
		fin_go   = (state_q == mavg_pkg::ST_FIN) && (!out_valid_q || out_ready);
		case (state_q)
			mavg_pkg::ST_IDLE: begin
				if (accept && win_full) begin
					state_d = mavg_pkg::ST_DIV;
				end
			end
			mavg_pkg::ST_DIV: begin
				if (bit_q == '0) begin
					state_d = mavg_pkg::ST_FIN;
				end
			end
			mavg_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = mavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mavg_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window length, running sum, fill count, write pointer and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= mavg_pkg::LEN_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
				sum_q <= '0;
				cnt_q <= '0;
				wp_q  <= '0;
			end else if (accept) begin
				sum_q <= new_sum;
				wp_q  <= wp_next;
				cnt_q <= win_full ? (eff_len - CNT_W'(1)) : cnt_inc[CNT_W-1:0];
			end else if (fin_go) begin
				sum_q <= sum_q - rd_ext;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q    <= new_mag;
			rem_q    <= '0;
			neg_q    <= new_sum[SUM_W-1];
			bit_q    <= BC_W'(SUM_W - 1);
			oldest_q <= oldest_w[PTR_W-1:0];
		end else if (state_q == mavg_pkg::ST_DIV) begin
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
			rem_q <= rem_nx;
			bit_q <= bit_q - BC_W'(1);
		end
		if (fin_go) begin
			avg_q <= quot_signed[SAMPLE_BITS-1:0];
		end
	end

	// window store: written on intake, oldest entry read back during the divide
	always_ff @(posedge clk) begin
		if (accept) begin
			window_store_q[slot] <= sample;
		end
		rd_q <= window_store_q[oldest_q];
	end

	assign out_valid = out_valid_q;
	assign average   = avg_q;

endmodule

// ----- src/mavg_checker.sv -----
// mavg_checker: port-level checks for the moving average filter, bound to the top level
// depends on moving_average_filter_unit port names
module mavg_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] average
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average))
		else $error("result changed while stalled");

	// ready only drops after an item was taken
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input stalled without an item");

	// ready stays low after it drops, while the divide runs
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |=> !in_ready)
		else $error("busy period too short");

	// a new result only appears at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a divide");

	// no result is pending out of reset
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind moving_average_filter_unit mavg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mavg_checker (.*);

// ----- dv/moving_average_filter_unit_test.sv -----
// moving_average_filter_unit_test: self-checking bench for the boxcar moving average filter
// drives items and window length writes, predicts each average and checks it in order
// depends on: mavg_pkg, moving_average_filter_unit
module moving_average_filter_unit_test;

	localparam int WIN_MAX = 64;
	localparam int SMP_W = 16;
	localparam int LW = mavg_pkg::LEN_W;
	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
	localparam int DRAIN_CYCLES = 32;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DIR_ROWS = 24;
	localparam int SWEEP_LEN = 7;
	localparam logic [LW-1:0] LENGTH_SWEEP [SWEEP_LEN] =
		'{7'd127, 7'd64, 7'd0, 7'd65, 7'd3, 7'd1, 7'd8};

	typedef enum logic {ROW_ITEM, ROW_LENGTH} row_kind_t;
	typedef enum int {FILL_MAX, FILL_MIN, FILL_TINY, FILL_SWING, FILL_RANDOM} fill_mode_t;

	typedef struct {
		row_kind_t kind;
		logic [LW-1:0] length;
		logic signed [SMP_W-1:0] smp;
		logic first;
		bit known;
		logic signed [SMP_W-1:0] avg;
	} stim_row_t;

	// directed rows: reset length, unit windows, zero length, truncation toward zero
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b1, SMP_MAX},
		'{ROW_ITEM,   7'd0, SMP_MIN,     1'b0, 1'b0, 16'sd0},
		'{ROW_LENGTH, 7'd1, 16'sd0,      1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b1, 1'b1, SMP_MAX},
		'{ROW_ITEM,   7'd0, SMP_MIN,     1'b0, 1'b1, SMP_MIN},
		'{ROW_ITEM,   7'd0, 16'sd0,      1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,   7'd0, -16'sd1,     1'b0, 1'b1, -16'sd1},
		'{ROW_LENGTH, 7'd0, 16'sd0,      1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, 16'sd12345,  1'b0, 1'b1, 16'sd12345},
		'{ROW_ITEM,   7'd0, -16'sd7,     1'b1, 1'b1, -16'sd7},
		'{ROW_LENGTH, 7'd2, 16'sd0,      1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, 16'sd1,      1'b1, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, -16'sd2,     1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,   7'd0, 16'sd3,      1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MIN,     1'b1, 1'b0, 16'sd0},
		'{ROW_ITEM,   7'd0, SMP_MIN,     1'b0, 1'b1, SMP_MIN},
		'{ROW_ITEM,   7'd0, SMP_MAX,     1'b0, 1'b0, 16'sd0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic signed [SMP_W-1:0] sample;
	logic block_start;
	logic out_valid;
	logic out_ready;
	logic signed [SMP_W-1:0] average;

	// predictor state
	logic [LW-1:0] len_reg;
	logic signed [SMP_W-1:0] win_mem [WIN_MAX];
	longint win_sum;
	int win_fill;
	int win_ptr;

	logic signed [SMP_W-1:0] expected_averages [$];
	logic signed [SMP_W-1:0] want_avg;
	int error_count;
	int rx_stall;
	int idle_run;
	bit no_gaps;

	moving_average_filter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.block_start(block_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// gap length: mostly none or short, a few long
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// divisor in use: zero acts as one, large values clamp to the store depth
	function automatic int window_span();
		if (len_reg == 0) return 1;
		if (len_reg > WIN_MAX) return WIN_MAX;
		return int'(len_reg);
	endfunction

	function automatic void clear_window();
		win_sum = 0;
		win_fill = 0;
		win_ptr = 0;
	endfunction

	// take one item into the window; returns 1 with the average once the window is full
	function automatic bit average_step(input logic signed [SMP_W-1:0] s, input logic first,
		output logic signed [SMP_W-1:0] avg);
		int n;
		int slot;
		longint q;
		n = window_span();
		if (first) clear_window();
		slot = win_ptr;
		win_mem[slot] = s;
		win_sum += s;
		win_ptr = (slot + 1) % WIN_MAX;
		avg = '0;
		if (win_fill + 1 < n) begin
			win_fill++;
			return 1'b0;
		end
		q = win_sum / n;
		avg = q[SMP_W-1:0];
		win_sum -= win_mem[(slot + WIN_MAX + 1 - n) % WIN_MAX];
		win_fill = n - 1;
		return 1'b1;
	endfunction

	task automatic log_error(input string msg);
		error_count++;
		if (error_count <= 10) $display("%s", msg);
	endtask

	// send one item, then record the average it should produce
	task automatic issue_item(input logic signed [SMP_W-1:0] s, input logic first,
		input bit known, input logic signed [SMP_W-1:0] known_avg);
		int gap;
		logic signed [SMP_W-1:0] got;
		gap = idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		block_start <= first;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (average_step(s, first, got)) expected_averages.push_back(known ? known_avg : got);
	endtask

	// hold off the sender until every average is back and the block has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_averages.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_length(input logic [LW-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_reg = v;
		clear_window();
	endtask

	// result side: check each accepted average, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_averages.size() == 0) begin
				log_error($sformatf("unexpected average %0d", average));
			end else begin
				want_avg = expected_averages.pop_front();
				if (average !== want_avg)
					log_error($sformatf("average mismatch: expected %0d, got %0d",
						want_avg, average));
			end
		end
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0) rx_stall = idle_span();
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_run = 0;
			else idle_run++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int i;
		int p;
		int k;
		int blk;
		int span;
		int r;
		int phase_target;
		int phase_count;
		int sent;
		logic [LW-1:0] len_pick;
		logic signed [SMP_W-1:0] smp;
		logic first;
		fill_mode_t mode;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		sample = '0;
		block_start = 1'b0;
		out_ready = 1'b0;
		error_count = 0;
		rx_stall = 0;
		no_gaps = 1'b0;
		len_reg = mavg_pkg::LEN_RESET;
		clear_window();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_LENGTH) program_length(directed_rows[i].length);
			else issue_item(directed_rows[i].smp, directed_rows[i].first,
				directed_rows[i].known, directed_rows[i].avg);
		end

		// random phases, each at a new window length, extremes first
		p = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len_pick = (p < SWEEP_LEN) ? LENGTH_SWEEP[p] : LW'($urandom_range(0, 127));
			p++;
			no_gaps = ($urandom_range(0, 3) == 0);
			program_length(len_pick);
			phase_target = 120 + $urandom_range(0, 80);
			phase_count = 0;
			while (phase_count < phase_target) begin
				span = window_span();
				// mostly full windows, now and then a block cut short
				if (span > 1 && $urandom_range(0, 7) == 0) blk = $urandom_range(1, span - 1);
				else blk = span + $urandom_range(0, 2 * span + 4);
				r = $urandom_range(0, 7);
				mode = (r > 4) ? FILL_RANDOM : fill_mode_t'(r);
				for (k = 0; k < blk; k++) begin
					case (mode)
						FILL_MAX: smp = SMP_MAX;
						FILL_MIN: smp = SMP_MIN;
						FILL_TINY: smp = SMP_W'($urandom_range(0, 8) - 4);
						FILL_SWING: smp = k[0] ? SMP_MAX : SMP_MIN;
						default: smp = SMP_W'($urandom);
					endcase
					first = (k == 0) && ($urandom_range(0, 5) != 0);
					if ($urandom_range(0, 99) == 0) wait_drained();
					issue_item(smp, first, 1'b0, '0);
					phase_count++;
				end
			end
			sent += phase_count;
		end

		wait_drained();
		if (error_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
